/* src/hill_cipher_encrypt_3x3_core_macros.svh */
// Assertion macros for the Hill cipher core; only hce_back includes them.
// HCE_ASSERT is silent while reset is asserted; HCE_ASSERT_ALWAYS checks at every edge.
`ifndef HILL_CIPHER_ENCRYPT_3X3_CORE_MACROS_SVH
`define HILL_CIPHER_ENCRYPT_3X3_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HCE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCE_ASSERT(lbl, clk, rstn, prop, msg)
`define HCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/hce_pkg.sv */
package hce_pkg;

  localparam int BLOCK_LEN = 3;
  localparam int SYM_W = 5;
  localparam int CODE_IN_W = 8;
  localparam int CODE_OUT_W = 7;
  localparam int KEY_ROW_W = BLOCK_LEN * SYM_W;
  localparam int CFG_IDX_W = 2;
  // Three products of a 5-bit key entry and a symbol below 26 stay below 2^12.
  localparam int ACC_W = 12;
  localparam int RECIP_W = 16;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int QUEUE_DEPTH = 2;
  localparam int ROW_W = 2;

  localparam logic [CODE_IN_W-1:0] LETTER_BASE = 8'd65;
  localparam logic [CODE_IN_W-1:0] LETTER_COUNT = 8'd26;

  localparam logic [CFG_IDX_W-1:0] KEY_ROW_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_ROW_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_ROW_TWO  = 2'd2;

  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  typedef logic [KEY_ROW_W-1:0] key_row_t;

  typedef struct packed {
    key_row_t row_two;
    key_row_t row_one;
    key_row_t row_zero;
  } key_rows_t;

  typedef struct packed {
    logic [BLOCK_LEN-1:0][SYM_W-1:0] sym;
    logic                            msg_end;
  } block_t;

  typedef struct packed {
    logic row_last;
    logic msg_done;
  } beat_tag_t;

endpackage

/* src/hill_cipher_encrypt_3x3_core.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid_i / in_stall_o   | letter_code_i[7:0], message_end_i
// output   | out_valid_o / out_stall_i | cipher_code_o[6:0], block_last_o, message_done_o
// config   | cfg_we_i                  | cfg_idx_i[1:0], cfg_wdata_i[14:0]
//
// One letter beat is taken per cycle while in_stall_o is low; each finished block
// yields three cipher beats, one per cycle unless out_stall_i holds them, so a steady
// stream keeps one beat per cycle on both sides. A finished block waits in the queue,
// then its beats pass three stages (dot product, quotient, remainder).
// Reset clears the key rows, the open block and all valid flags at once.
// A stalled output holds the whole back pipeline; the two-entry block queue keeps
// the input flowing until it fills, and then in_stall_o rises.

module hill_cipher_encrypt_3x3_core #(
  parameter int ALPHABET_SIZE = hce_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hce_pkg::CODE_IN_W-1:0]   letter_code_i,
  input  logic                            message_end_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hce_pkg::CODE_OUT_W-1:0]  cipher_code_o,
  output logic                            block_last_o,
  output logic                            message_done_o,
  input  logic                            cfg_we_i,
  input  logic [hce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hce_pkg::KEY_ROW_W-1:0]   cfg_wdata_i
);
  import hce_pkg::*;

  // Key matrix rows; the user must write them only while the core is idle (not enforced here).
  key_rows_t key_q;

  logic   push;
  block_t push_block;
  logic   pop;
  block_t head;
  logic   empty;
  logic   full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      // An index past the last row is ignored.
      unique case (cfg_idx_i)
        KEY_ROW_ZERO: key_q.row_zero <= cfg_wdata_i;
        KEY_ROW_ONE:  key_q.row_one <= cfg_wdata_i;
        KEY_ROW_TWO:  key_q.row_two <= cfg_wdata_i;
        default:      key_q <= key_q;
      endcase
    end
  end

  // The front maps bytes to symbols and gathers them into padded blocks.
  hce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .letter_code_i (letter_code_i),
    .message_end_i (message_end_i),
    .full_i        (full),
    .push_o        (push),
    .block_o       (push_block)
  );

  // Short queue of completed blocks decouples the two halves.
  hce_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_block_i (push_block),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .full_o       (full)
  );

  // The back walks the three key rows of each block and reduces each sum.
  hce_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (key_q),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cipher_code_o  (cipher_code_o),
    .block_last_o   (block_last_o),
    .message_done_o (message_done_o)
  );

endmodule

/* src/hce_front.sv */
module hce_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hce_pkg::CODE_IN_W-1:0]  letter_code_i,
  input  logic                           message_end_i,
  input  logic                           full_i,
  output logic                           push_o,
  output hce_pkg::block_t                block_o
);
  import hce_pkg::*;

  logic [1:0]       fill_q, fill_d;
  logic [SYM_W-1:0] buf0_q, buf0_d, buf1_q, buf1_d;
  logic [SYM_W-1:0] sym;
  logic             accept;
  logic             complete;

  assign in_stall_o = full_i;
  assign accept = in_valid_i && !full_i;

  always_comb begin
    if (letter_code_i >= LETTER_BASE && letter_code_i < LETTER_BASE + LETTER_COUNT) begin
      sym = SYM_W'(letter_code_i - LETTER_BASE);
    end else begin
      sym = '0;
    end
  end

  // A count of three never arises; it is handled like two.
  assign complete = message_end_i || (fill_q >= 2'd2);

  always_comb begin
    block_o.msg_end = message_end_i;
    unique case (fill_q)
      2'd0: begin
        block_o.sym[0] = sym;
        block_o.sym[1] = '0;
        block_o.sym[2] = '0;
      end
      2'd1: begin
        block_o.sym[0] = buf0_q;
        block_o.sym[1] = sym;
        block_o.sym[2] = '0;
      end
      default: begin
        block_o.sym[0] = buf0_q;
        block_o.sym[1] = buf1_q;
        block_o.sym[2] = sym;
      end
    endcase
  end

  assign push_o = accept && complete;

  always_comb begin
    fill_d = fill_q;
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    if (accept) begin
      if (complete) begin
        fill_d = 2'd0;
        buf0_d = '0;
        buf1_d = '0;
      end else begin
        fill_d = fill_q + 2'd1;
        if (fill_q == 2'd0) begin
          buf0_d = sym;
        end else begin
          buf1_d = sym;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      buf0_q <= '0;
      buf1_q <= '0;
    end else begin
      fill_q <= fill_d;
      buf0_q <= buf0_d;
      buf1_q <= buf1_d;
    end
  end

endmodule

/* src/hce_queue.sv */
module hce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hce_pkg::block_t push_block_i,
  input  logic            pop_i,
  output hce_pkg::block_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import hce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  block_t           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == CNT_FULL);
  assign head_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_block_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* src/hce_back.sv */
`include "hill_cipher_encrypt_3x3_core_macros.svh"

module hce_back #(
  parameter int ALPHABET_SIZE = hce_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hce_pkg::key_rows_t              key_i,
  input  hce_pkg::block_t                 head_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hce_pkg::CODE_OUT_W-1:0]  cipher_code_o,
  output logic                            block_last_o,
  output logic                            message_done_o
);
  import hce_pkg::*;

  localparam int RES_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int PROD_W = ACC_W + RECIP_W;
  localparam int RECIP = (1 << RECIP_W) / ALPHABET_SIZE;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [ACC_W-1:0] MOD_V = ACC_W'(ALPHABET_SIZE);

  logic [ROW_W-1:0] row_q, row_d;
  logic             adv;
  logic             issue;
  key_row_t         key_row;
  logic [ACC_W-1:0] acc_a;

  logic             va_q, vb_q, vc_q;
  logic [ACC_W-1:0] acc_a_q, acc_b_q;
  logic [ACC_W-1:0] quo_b_q;
  beat_tag_t        tag_a_q, tag_b_q, tag_c_q;
  logic [CODE_OUT_W-1:0] code_c_q;

  logic [PROD_W-1:0]  prod_b;
  logic [2*ACC_W-1:0] qn_c;
  logic [ACC_W-1:0]   rem_c, rem_fix_c;
  logic [RES_W-1:0]   res_c;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv = !vc_q || !out_stall_i;
  assign issue = adv && !empty_i;
  assign pop_o = issue && (row_q == ROW_LAST);

  always_comb begin
    unique case (row_q)
      KEY_ROW_ZERO: key_row = key_i.row_zero;
      KEY_ROW_ONE:  key_row = key_i.row_one;
      KEY_ROW_TWO:  key_row = key_i.row_two;
      default:      key_row = '0;
    endcase
  end

  // Both factors are widened first so that each product keeps all of its bits.
  always_comb begin
    acc_a = '0;
    for (int c = 0; c < BLOCK_LEN; c++) begin
      acc_a = acc_a + ACC_W'(key_row[c*SYM_W +: SYM_W]) * ACC_W'(head_i.sym[c]);
    end
  end

  always_comb begin
    row_d = row_q;
    if (issue) begin
      row_d = (row_q == ROW_LAST) ? ROW_FIRST : row_q + ROW_W'(1);
    end
  end

  // Quotient estimate by reciprocal; it may fall short by one.
  assign prod_b = PROD_W'(acc_a_q) * PROD_W'(RECIP_V);
  assign qn_c = quo_b_q * MOD_V;
  assign rem_c = acc_b_q - qn_c[ACC_W-1:0];
  assign rem_fix_c = (rem_c >= MOD_V) ? rem_c - MOD_V : rem_c;
  assign res_c = rem_fix_c[RES_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= ROW_FIRST;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      row_q <= row_d;
      if (adv) begin
        va_q <= issue;
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc_a_q <= acc_a;
      tag_a_q.row_last <= (row_q == ROW_LAST);
      tag_a_q.msg_done <= (row_q == ROW_LAST) && head_i.msg_end;
      acc_b_q <= acc_a_q;
      quo_b_q <= prod_b[PROD_W-1:RECIP_W];
      tag_b_q <= tag_a_q;
      code_c_q <= CODE_OUT_W'(LETTER_BASE) + CODE_OUT_W'(res_c);
      tag_c_q <= tag_b_q;
    end
  end

  assign out_valid_o = vc_q;
  assign cipher_code_o = code_c_q;
  assign block_last_o = tag_c_q.row_last;
  assign message_done_o = tag_c_q.msg_done;

  `HCE_ASSERT(a_done_on_last, clk_i, rst_ni, (vc_q && tag_c_q.msg_done) |-> tag_c_q.row_last, "message_done without block_last")
  `HCE_ASSERT(a_held_beat_stays, clk_i, rst_ni, (vc_q && out_stall_i) |=> (vc_q && $stable(code_c_q)), "held beat was lost")
  `HCE_ASSERT(a_row_range, clk_i, rst_ni, row_q <= ROW_LAST, "row counter out of range")

endmodule
